[rtl/core/itoa_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII converter.
// Used by the controller, the datapath and the top level; depends on nothing.

package itoa_pkg;

   // ASCII codes that the converter emits.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the input value and clear the BCD register
      logic conv_step;   // one double-dabble adjust-and-shift step
      logic digit_shift; // drop the top BCD digit
      logic emit_sign;   // present '-' on the result ports
      logic emit_digit;  // present the top BCD digit on the result ports
      logic emit_last;   // the emitted digit ends the text
   } itoa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic neg;         // the captured value is negative
      logic top_zero;    // the top BCD digit is zero
   } itoa_status_type;

endpackage

[rtl/core/itoa_dp.sv]
// Datapath of the decimal converter: magnitude, shift-add-3 BCD register and
// the registered result ports. Depends on itoa_pkg.

module itoa_dp #(
   parameter int INPUT_WIDTH = 32,
   parameter int NUM_DIGITS  = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [INPUT_WIDTH-1:0]       req_value,
   input  itoa_pkg::itoa_cmd_type       cmd,
   output itoa_pkg::itoa_status_type    status,
   output logic                         rsp_strobe,
   output logic [7:0]                   rsp_character,
   output logic                         rsp_last
);
   import itoa_pkg::*;

   localparam int BCD_WIDTH = 4 * NUM_DIGITS;

   logic                   neg_ff;
   logic [INPUT_WIDTH-1:0] mag_ff;
   logic [INPUT_WIDTH-1:0] mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff;
   logic [BCD_WIDTH-1:0]   bcd_adj;
   logic                   strobe_ff;
   logic [7:0]             char_ff;
   logic                   last_ff;
   logic [3:0]             top_digit;

   // The magnitude is formed as unsigned, so the most negative value fits.
   assign mag_in = req_value[INPUT_WIDTH-1]
                   ? (~req_value) + {{(INPUT_WIDTH-1){1'b0}}, 1'b1}
                   : req_value;

   // Each BCD digit of five or more is corrected before the next shift.
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[INPUT_WIDTH-1];
         mag_ff <= mag_in;
         bcd_ff <= '0;
      end else if (cmd.conv_step) begin
         bcd_ff <= {bcd_adj[BCD_WIDTH-2:0], mag_ff[INPUT_WIDTH-1]};
         mag_ff <= {mag_ff[INPUT_WIDTH-2:0], 1'b0};
      end else if (cmd.digit_shift) begin
         bcd_ff <= {bcd_ff[BCD_WIDTH-5:0], 4'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit_sign | cmd.emit_digit;
         last_ff   <= cmd.emit_digit & cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         char_ff <= CHAR_MINUS;
      end else if (cmd.emit_digit) begin
         char_ff <= CHAR_ZERO | {4'd0, top_digit};
      end
   end

   assign status.neg      = neg_ff;
   assign status.top_zero = (top_digit == 4'd0);
   assign rsp_strobe      = strobe_ff;
   assign rsp_character   = char_ff;
   assign rsp_last        = last_ff;

endmodule

[rtl/core/itoa_ctrl.sv]
// Controller of the decimal converter: sequences conversion, leading-zero
// skipping and character output. Depends on itoa_pkg.

module itoa_ctrl #(
   parameter int INPUT_WIDTH = 32,
   parameter int NUM_DIGITS  = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  itoa_pkg::itoa_status_type    status,
   output itoa_pkg::itoa_cmd_type       cmd
);
   import itoa_pkg::*;

   localparam int BIT_CNT_WIDTH   = $clog2(INPUT_WIDTH + 1);
   localparam int DIGIT_CNT_WIDTH = $clog2(NUM_DIGITS + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CONVERT = 3'd1;
   localparam logic [2:0] ST_SKIP    = 3'd2;
   localparam logic [2:0] ST_SIGN    = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   logic [2:0]                 state_ff, state_in;
   logic [BIT_CNT_WIDTH-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIGIT_CNT_WIDTH-1:0] digit_cnt_ff, digit_cnt_in;
   logic                       digit_one;

   assign digit_one = (digit_cnt_ff == DIGIT_CNT_WIDTH'(1));

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load   = 1'b1;
               bit_cnt_in = BIT_CNT_WIDTH'(INPUT_WIDTH);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            bit_cnt_in    = bit_cnt_ff - BIT_CNT_WIDTH'(1);
            if (bit_cnt_ff == BIT_CNT_WIDTH'(1)) begin
               digit_cnt_in = DIGIT_CNT_WIDTH'(NUM_DIGITS);
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Leading zeros are dropped, but the units digit always stays.
            if (status.top_zero && !digit_one) begin
               cmd.digit_shift = 1'b1;
               digit_cnt_in    = digit_cnt_ff - DIGIT_CNT_WIDTH'(1);
            end else if (status.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_digit  = 1'b1;
            cmd.emit_last   = digit_one;
            cmd.digit_shift = 1'b1;
            digit_cnt_in    = digit_cnt_ff - DIGIT_CNT_WIDTH'(1);
            if (digit_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         digit_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         digit_cnt_ff <= digit_cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Instantiates itoa_ctrl and itoa_dp; depends on itoa_pkg.
//
//   Channel   Ports                                   Transfer when
//   input     start, busy, req_value                  start && !busy
//   result    rsp_strobe, rsp_character, rsp_last     rsp_strobe
//
// An item goes through one load step, one shift-add-3 step per input bit, one
// step per skipped leading zero plus one, a step for a sign, and one per digit.
// Skipped zeros and digits always add up to NUM_DIGITS. The bit-serial BCD
// conversion sets most of the time an item takes. Reset clears the controller,
// the result strobe and the last flag; nothing is kept between items. The
// receiver cannot stall: each character is shown for exactly one cycle.

module signed_int_to_decimal_ascii #(
   parameter int INPUT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [INPUT_WIDTH-1:0] req_value,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_character,
   output logic                          rsp_last
);
   import itoa_pkg::*;

   // Digits of the largest magnitude, 2**(INPUT_WIDTH-1); 1233/4096 ~ log10(2).
   localparam int NUM_DIGITS = (((INPUT_WIDTH - 1) * 1233) >> 12) + 1;

   itoa_cmd_type    cmd;
   itoa_status_type status;

   itoa_ctrl #(
      .INPUT_WIDTH (INPUT_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   itoa_dp #(
      .INPUT_WIDTH (INPUT_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_value     ($unsigned(req_value)),
      .cmd           (cmd),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   a_strobe_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Result strobe without an item in progress.");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted transfer did not make the block busy.");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.conv_step, cmd.emit_sign, cmd.emit_digit}))
      else $error("Conflicting datapath commands.");

   a_last_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("Last flag outside a result transfer.");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for signed_int_to_decimal_ascii: drives integers, predicts their
// decimal text character by character and checks every result transfer. Depends on itoa_pkg.

module testbench;
   import itoa_pkg::*;

   localparam int WIDTH       = 32;
   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      logic [WIDTH-1:0] value;
      int unsigned      gap;
      bit               drain;
   } conversion_req_type;

   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [WIDTH-1:0] req_value = '0;
   logic             rsp_strobe;
   logic [7:0]       rsp_character;
   logic             rsp_last;

   conversion_req_type value_queue[$];
   text_char_type      text_fifo[$];
   logic               req_taken = 1'b0;
   int unsigned        idle_count = 0;
   int unsigned        stall_cycles = 0;
   int unsigned        error_count = 0;

   signed_int_to_decimal_ascii #(.INPUT_WIDTH(WIDTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Works out the characters of one value: sign first, then the digits of the
   // magnitude taken as unsigned, so that the most negative value is whole.
   task automatic queue_decimal_text(input logic [WIDTH-1:0] value);
      logic [WIDTH-1:0] magnitude;
      logic [7:0]       digits[$];
      text_char_type    entry;
      magnitude = value[WIDTH-1] ? -value : value;
      do begin
         digits.push_front(CHAR_ZERO + 8'(magnitude % 10));
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[WIDTH-1]) begin
         entry.character = CHAR_MINUS;
         entry.last      = 1'b0;
         text_fifo.push_back(entry);
      end
      for (int i = 0; i < digits.size(); i++) begin
         entry.character = digits[i];
         entry.last      = (i == digits.size() - 1);
         text_fifo.push_back(entry);
      end
   endtask

   task automatic add_value(input logic [WIDTH-1:0] value, input int unsigned gap,
                            input bit drain);
      conversion_req_type item;
      item.value = value;
      item.gap   = gap;
      item.drain = drain;
      value_queue.push_back(item);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return $urandom_range(0, 6);
      else if (roll < 92)
         return $urandom_range(7, 60);
      else
         return $urandom_range(61, 200);
   endfunction

   // Mixes full-range words with values of a chosen digit count, powers of ten
   // and their neighbours, and values close to zero.
   function automatic logic [WIDTH-1:0] random_value();
      logic [WIDTH-1:0] value;
      int unsigned      digit_count;
      case ($urandom_range(0, 3))
         0: begin
            return $urandom;
         end
         1: begin
            digit_count = $urandom_range(1, 9);
            value = 1;
            repeat (digit_count) value = value * 10;
            value = $urandom % value;
         end
         2: begin
            value = 1;
            repeat ($urandom_range(0, 9)) value = value * 10;
            value = value + $urandom_range(0, 2) - 1;
         end
         default: begin
            value = $urandom_range(0, 20);
         end
      endcase
      if ($urandom_range(0, 1))
         value = -value;
      return value;
   endfunction

   // The driver: a new item goes out once the previous one has been taken
   // and its gap has passed; a drain item also waits for all text to arrive.
   always @(negedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         idle_count <= 0;
      end else if (!start || req_taken) begin
         if (value_queue.size() == 0) begin
            start <= 1'b0;
         end else if (idle_count < value_queue[0].gap) begin
            start      <= 1'b0;
            idle_count <= idle_count + 1;
         end else if (value_queue[0].drain && text_fifo.size() != 0) begin
            start <= 1'b0;
         end else begin
            req_value  <= value_queue[0].value;
            start      <= 1'b1;
            idle_count <= 0;
            void'(value_queue.pop_front());
         end
      end
   end

   // The monitor: records input transfers, checks each character and keeps
   // the watchdog.
   always @(posedge clock) begin
      text_char_type wanted;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_taken <= start && !busy;
         if (start && !busy)
            queue_decimal_text(req_value);
         if (rsp_strobe) begin
            if (text_fifo.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                         rsp_character, rsp_last));
            end else begin
               wanted = text_fifo.pop_front();
               if (rsp_character !== wanted.character)
                  report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                            rsp_character, wanted.character));
               if (rsp_last !== wanted.last)
                  report_mismatch($sformatf("last %0b, wanted %0b on character 0x%02h",
                                            rsp_last, wanted.last, wanted.character));
            end
         end
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("signed_int_to_decimal_ascii: mismatch");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      add_value(32'd0, 0, 1'b0);
      add_value(32'd1, 0, 1'b0);
      add_value(-32'sd1, 0, 1'b0);
      add_value(32'd9, 0, 1'b0);
      add_value(32'd10, 0, 1'b0);
      add_value(-32'sd10, 0, 1'b0);
      add_value(32'd99, 0, 1'b0);
      add_value(32'd100, 0, 1'b0);
      add_value(-32'sd5, 0, 1'b0);
      add_value(32'd42, 0, 1'b0);
      add_value(32'h7FFF_FFFF, 0, 1'b0);
      add_value(32'h8000_0000, 0, 1'b0);
      add_value(32'h8000_0001, 0, 1'b0);
      add_value(32'd1000000000, 0, 1'b0);
      add_value(32'd999999999, 0, 1'b0);
      add_value(-32'sd999999999, 0, 1'b0);
      add_value(32'd1234567890, 0, 1'b0);
      add_value(-32'sd1234567890, 0, 1'b0);
      add_value(32'hFFFF_FFF6, 0, 1'b0);
      add_value(32'h5555_5555, 0, 1'b0);
      add_value(32'hAAAA_AAAA, 0, 1'b0);
      for (int i = 0; i < 110; i++) begin
         // Every third run of fifteen items goes back to back.
         add_value(random_value(), ((i / 15) % 3 == 1) ? 0 : pick_gap(),
                   i == 0 || i == 70);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (value_queue.size() != 0 || start)
         @(negedge clock);
      while (text_fifo.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("signed_int_to_decimal_ascii: match");
      else
         $display("signed_int_to_decimal_ascii: mismatch");
      $finish;
   end

endmodule
